// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the segment header encoder modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SHE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define SHE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hdl/she_pkg.sv =====
// ---------------------------------------------------------------------------
// she_pkg
// Types, constants and helpers of the segment header encoder.
// ---------------------------------------------------------------------------
package she_pkg;

    localparam logic [3:0] VERSION       = 4'd1;
    localparam logic       CHECKSUM_FLAG = 1'b1;

    localparam logic [7:0] LEN_PLAIN = 8'd8;
    localparam logic [7:0] LEN_SYN   = 8'd24;

    localparam logic [3:0] LAST_PLAIN = 4'd3;
    localparam logic [3:0] LAST_SYN   = 4'd11;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_OUTSTANDING  = 4'd0,
        REG_MAX_SEGMENT_SIZE = 4'd1,
        REG_RETRANSMIT_TO    = 4'd2,
        REG_CUM_ACK_TO       = 4'd3,
        REG_IDLE_TO          = 4'd4,
        REG_RETRY_LIMITS     = 4'd5,
        REG_TIME_UNIT        = 4'd6,
        REG_CONNECTION_ID    = 4'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0]  max_outstanding;
        logic [15:0] max_segment_size;
        logic [15:0] retransmit_timeout;
        logic [15:0] cumulative_ack_timeout;
        logic [15:0] idle_timeout;
        logic [15:0] retry_limits;
        logic [7:0]  time_unit;
        logic [31:0] connection_id;
    } t_cfg;

    typedef struct packed {
        logic       syn_flag;
        logic       ack_flag;
        logic       reset_flag;
        logic       null_flag;
        logic       busy_flag;
        logic [7:0] seq_number;
        logic [7:0] ack_number;
    } t_seg;

    // finished header handed to the serializer
    typedef struct packed {
        logic        syn;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [15:0] csum;
    } t_hdr;

    function automatic logic [15:0] she_word2(input t_cfg cfg);
        she_word2 = {VERSION, 1'b1, CHECKSUM_FLAG, 2'b00, cfg.max_outstanding};
    endfunction

endpackage

// ===== hdl/she_seg_if.sv =====
// ---------------------------------------------------------------------------
// she_seg_if
// Segment request channel: valid/ready with the request fields.
// ---------------------------------------------------------------------------
interface she_seg_if;
    logic       valid;
    logic       ready;
    logic       syn_flag;
    logic       ack_flag;
    logic       reset_flag;
    logic       null_flag;
    logic       busy_flag;
    logic [7:0] seq_number;
    logic [7:0] ack_number;

    modport source (
        output valid, syn_flag, ack_flag, reset_flag, null_flag, busy_flag,
               seq_number, ack_number,
        input  ready
    );
    modport sink (
        input  valid, syn_flag, ack_flag, reset_flag, null_flag, busy_flag,
               seq_number, ack_number,
        output ready
    );
endinterface

// ===== hdl/she_hdr_if.sv =====
// ---------------------------------------------------------------------------
// she_hdr_if
// Header word channel: valid/ready with one header word per transfer.
// ---------------------------------------------------------------------------
interface she_hdr_if;
    logic        valid;
    logic        ready;
    logic [15:0] header_word;
    logic [3:0]  word_index;
    logic        last_word;

    modport source (
        output valid, header_word, word_index, last_word,
        input  ready
    );
    modport sink (
        input  valid, header_word, word_index, last_word,
        output ready
    );
endinterface

// ===== hdl/she_hdr_pipe.sv =====
// ---------------------------------------------------------------------------
// she_hdr_pipe
// Three-stage header build: word setup and partial sums, total, checksum.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module she_hdr_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  she_pkg::t_seg   i_seg,
    input  she_pkg::t_cfg   i_cfg,
    output logic            o_valid,
    input  logic            i_ready,
    output she_pkg::t_hdr   o_hdr
);

    typedef struct packed {
        logic        syn;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [17:0] sa;
        logic [17:0] sb;
        logic [17:0] sc;
    } t_s1;

    typedef struct packed {
        logic        syn;
        logic [15:0] w0;
        logic [15:0] w1;
        logic [19:0] tot;
    } t_s2;

    logic          r_v1, r_v2, r_v3;
    t_s1           r_s1, n_s1;
    t_s2           r_s2, n_s2;
    she_pkg::t_hdr r_s3, n_s3;
    logic          rdy1, rdy2, rdy3;
    logic [16:0]   fold1;
    logic [15:0]   fold2;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        n_s1.syn = i_seg.syn_flag;
        n_s1.w0  = {i_seg.syn_flag, i_seg.ack_flag, 1'b0, i_seg.reset_flag,
                    i_seg.null_flag, 2'b00, i_seg.busy_flag,
                    i_seg.syn_flag ? she_pkg::LEN_SYN : she_pkg::LEN_PLAIN};
        n_s1.w1  = {i_seg.seq_number, i_seg.ack_number};
        n_s1.sa  = {2'b00, n_s1.w0} + {2'b00, n_s1.w1}
                 + (i_seg.syn_flag ? {2'b00, she_pkg::she_word2(i_cfg)} : 18'd0);
        if (i_seg.syn_flag) begin
            n_s1.sb = {2'b00, i_cfg.max_segment_size} + {2'b00, i_cfg.retransmit_timeout}
                    + {2'b00, i_cfg.cumulative_ack_timeout} + {2'b00, i_cfg.idle_timeout};
            n_s1.sc = {2'b00, i_cfg.retry_limits} + {10'd0, i_cfg.time_unit}
                    + {2'b00, i_cfg.connection_id[31:16]}
                    + {2'b00, i_cfg.connection_id[15:0]};
        end else begin
            n_s1.sb = '0;
            n_s1.sc = '0;
        end
    end

    always_comb begin
        n_s2.syn = r_s1.syn;
        n_s2.w0  = r_s1.w0;
        n_s2.w1  = r_s1.w1;
        n_s2.tot = {2'b00, r_s1.sa} + {2'b00, r_s1.sb} + {2'b00, r_s1.sc};
    end

    // end-around carry: two folds suffice for a 20-bit total
    always_comb begin
        fold1     = {1'b0, r_s2.tot[15:0]} + {13'd0, r_s2.tot[19:16]};
        fold2     = fold1[15:0] + {15'd0, fold1[16]};
        n_s3.syn  = r_s2.syn;
        n_s3.w0   = r_s2.w0;
        n_s3.w1   = r_s2.w1;
        n_s3.csum = ~fold2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_s1 <= n_s1;
        if (rdy2) r_s2 <= n_s2;
        if (rdy3) r_s3 <= n_s3;
    end

    assign o_valid = r_v3;
    assign o_hdr   = r_s3;

    `SHE_ASSERT(a_s3_hold, (r_v3 && !i_ready) |=> (r_v3 && $stable(r_s3)),
        "stalled header changed")
    `SHE_ASSERT(a_s2_hold, (r_v2 && !rdy2) |=> (r_v2 && $stable(r_s2)),
        "stalled stage two lost its word")

endmodule

// ===== hdl/segment_header_encoder_core.sv =====
// ---------------------------------------------------------------------------
// segment_header_encoder_core
// Builds reliable-link segment headers and sends them out as 16-bit words.
// ---------------------------------------------------------------------------
// Usage:
//   i_seg takes one segment request per transfer (valid/ready). o_hdr returns
//   the header as 16-bit words with word index and a last marker: 4 words
//   for a plain header, 12 for SYN; the last word is the checksum.
//   Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while the
//   block is idle; indexes beyond 7 are ignored.
// Path: a taken request has its word setup and partial sums registered in
//   stage one; the total, the carry fold and the serializer load are then
//   registered in turn before the first word of its header is valid.
// Throughput: the serializer sends one word per cycle while o_hdr.ready is
//   high; back-to-back requests stream with no gap between headers, and up
//   to three requests queue in the build stages.
// Reset: i_rst_n (synchronous) empties the stages and the serializer and
//   loads the register defaults.
// Stall: while o_hdr.ready is low the current word holds and the build
//   stages fill, then i_seg.ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_header_encoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    she_seg_if.sink                         i_seg,
    she_hdr_if.source                       o_hdr,
    input  logic                            i_cfg_we,
    input  logic [she_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [she_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    she_pkg::t_cfg r_cfg;
    she_pkg::t_seg seg;
    she_pkg::t_hdr pipe_hdr;
    she_pkg::t_hdr r_hdr;
    logic          pipe_valid;
    logic          pipe_ready;
    logic          r_busy;
    logic [3:0]    r_idx;
    logic          last;
    logic [15:0]   word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_outstanding        <= 8'd8;
            r_cfg.max_segment_size       <= 16'd1024;
            r_cfg.retransmit_timeout     <= 16'd10;
            r_cfg.cumulative_ack_timeout <= 16'd100;
            r_cfg.idle_timeout           <= 16'd100;
            r_cfg.retry_limits           <= 16'd4097;
            r_cfg.time_unit              <= 8'd3;
            r_cfg.connection_id          <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                she_pkg::REG_MAX_OUTSTANDING:  r_cfg.max_outstanding <= i_cfg_data[7:0];
                she_pkg::REG_MAX_SEGMENT_SIZE: r_cfg.max_segment_size <= i_cfg_data[15:0];
                she_pkg::REG_RETRANSMIT_TO:    r_cfg.retransmit_timeout <= i_cfg_data[15:0];
                she_pkg::REG_CUM_ACK_TO:       r_cfg.cumulative_ack_timeout <= i_cfg_data[15:0];
                she_pkg::REG_IDLE_TO:          r_cfg.idle_timeout <= i_cfg_data[15:0];
                she_pkg::REG_RETRY_LIMITS:     r_cfg.retry_limits <= i_cfg_data[15:0];
                she_pkg::REG_TIME_UNIT:        r_cfg.time_unit <= i_cfg_data[7:0];
                she_pkg::REG_CONNECTION_ID:    r_cfg.connection_id <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign seg = {i_seg.syn_flag, i_seg.ack_flag, i_seg.reset_flag, i_seg.null_flag,
                  i_seg.busy_flag, i_seg.seq_number, i_seg.ack_number};

    she_hdr_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_seg.valid),
        .o_ready (i_seg.ready),
        .i_seg   (seg),
        .i_cfg   (r_cfg),
        .o_valid (pipe_valid),
        .i_ready (pipe_ready),
        .o_hdr   (pipe_hdr)
    );

    // word serializer
    assign last       = (r_idx == (r_hdr.syn ? she_pkg::LAST_SYN : she_pkg::LAST_PLAIN));
    assign pipe_ready = !r_busy || (o_hdr.ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 4'd0;
        end else if (pipe_ready) begin
            r_busy <= pipe_valid;
            r_idx  <= 4'd0;
        end else if (o_hdr.ready) begin
            r_idx  <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ready && pipe_valid) r_hdr <= pipe_hdr;
    end

    always_comb begin
        if (last) begin
            word = r_hdr.csum;
        end else begin
            unique case (r_idx)
                4'd0:    word = r_hdr.w0;
                4'd1:    word = r_hdr.w1;
                4'd2:    word = r_hdr.syn ? she_pkg::she_word2(r_cfg) : 16'd0;
                4'd3:    word = r_cfg.max_segment_size;
                4'd4:    word = r_cfg.retransmit_timeout;
                4'd5:    word = r_cfg.cumulative_ack_timeout;
                4'd6:    word = r_cfg.idle_timeout;
                4'd7:    word = r_cfg.retry_limits;
                4'd8:    word = {8'd0, r_cfg.time_unit};
                4'd9:    word = r_cfg.connection_id[31:16];
                4'd10:   word = r_cfg.connection_id[15:0];
                default: word = 16'd0;
            endcase
        end
    end

    assign o_hdr.valid       = r_busy;
    assign o_hdr.header_word = word;
    assign o_hdr.word_index  = r_idx;
    assign o_hdr.last_word   = last;

    `SHE_ASSERT(a_idx_range, r_busy |-> (r_idx <= she_pkg::LAST_SYN),
        "word index past end of header")
    `SHE_ASSERT(a_idx_step, (r_busy && o_hdr.ready && !last) |=>
        (r_busy && r_idx == $past(r_idx) + 4'd1), "word index skipped")
    `SHE_ASSERT(a_new_hdr, (r_busy && o_hdr.ready && last) |=> (r_idx == 4'd0),
        "header did not restart at word zero")
    `SHE_ASSERT_ALWAYS(a_idle_idx, !r_busy |-> (r_idx == 4'd0),
        "idle serializer holds a nonzero index")

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_header_encoder_core. Segment requests go in
// over i_seg and every header word coming out of o_hdr is checked against
// a typed row's words or a local header builder tracking register settings.
// A short directed table comes first, then random requests under several
// register settings and idle/stall patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int         PLAIN_WORDS = int'(she_pkg::LAST_PLAIN) + 1;
    localparam int         SYN_WORDS   = int'(she_pkg::LAST_SYN) + 1;
    localparam int         MAX_ERR_PRINT = 10;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [3:0] REG_BEYOND = 4'd8;
    localparam int         NUM_DIR = 16;

    typedef struct packed {
        logic [15:0] word;
        logic [3:0]  idx;
        logic        last;
    } t_hdr_word;

    typedef struct packed {
        she_pkg::t_seg seg;
        logic          typed;
        logic [15:0]   w0;
        logic [15:0]   w1;
        logic [15:0]   csum;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic                           i_cfg_we;
    logic [she_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [she_pkg::CFG_DATA_W-1:0] i_cfg_data;

    she_seg_if seg_bus ();
    she_hdr_if hdr_bus ();

    segment_header_encoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seg      (seg_bus),
        .o_hdr      (hdr_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    she_pkg::t_cfg cfg_regs;
    t_hdr_word     hdr_expect_q[$];
    t_hdr_word     exp_w;
    t_hdr_word     got_w;
    int            mismatch_cnt;
    int            cycle_cnt;
    int            idle_pct;
    int            stall_pct;
    logic          hold_req;
    logic          hold_ack;
    int            hold_cnt;

    // typed rows carry their words; the other rows, SYN or plain, go through the header builder
    t_row dir_rows [NUM_DIR] = '{
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, 16'h0008, 16'h0000, 16'hfff7},
        '{'{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'hff, 8'hff}, 1'b1, 16'h5908, 16'hffff, 16'ha6f7},
        '{'{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, 16'h4008, 16'h0000, 16'hbff7},
        '{'{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, 16'h1008, 16'h0000, 16'heff7},
        '{'{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00}, 1'b1, 16'h0808, 16'h0000, 16'hf7f7},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00}, 1'b1, 16'h0108, 16'h0000, 16'hfef7},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'hff, 8'h00}, 1'b1, 16'h0008, 16'hff00, 16'h00f7},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'hff}, 1'b1, 16'h0008, 16'h00ff, 16'hfef8},
        '{'{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'hff, 8'hf7}, 1'b1, 16'h0008, 16'hfff7, 16'h0000},
        '{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hff, 8'hff}, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{'{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h80, 8'h01}, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h5a, 8'ha5}, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{'{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h3c, 8'hc3}, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hff, 8'h00}, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{'{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'h01, 8'h80}, 1'b0, 16'h0000, 16'h0000, 16'h0000}
    };

    always #1 i_clk = ~i_clk;

    task automatic apply_reg(input logic [she_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        case (idx)
            she_pkg::REG_MAX_OUTSTANDING:  cfg_regs.max_outstanding = data[7:0];
            she_pkg::REG_MAX_SEGMENT_SIZE: cfg_regs.max_segment_size = data[15:0];
            she_pkg::REG_RETRANSMIT_TO:    cfg_regs.retransmit_timeout = data[15:0];
            she_pkg::REG_CUM_ACK_TO:       cfg_regs.cumulative_ack_timeout = data[15:0];
            she_pkg::REG_IDLE_TO:          cfg_regs.idle_timeout = data[15:0];
            she_pkg::REG_RETRY_LIMITS:     cfg_regs.retry_limits = data[15:0];
            she_pkg::REG_TIME_UNIT:        cfg_regs.time_unit = data[7:0];
            she_pkg::REG_CONNECTION_ID:    cfg_regs.connection_id = data;
            default: ;
        endcase
    endtask

    task automatic build_expected_header(input she_pkg::t_seg s);
        logic [15:0] w [SYN_WORDS];
        logic [31:0] acc;
        int          n;
        for (int k = 0; k < SYN_WORDS; k++) w[k] = 16'h0000;
        n = s.syn_flag ? SYN_WORDS : PLAIN_WORDS;
        w[0] = {s.syn_flag, s.ack_flag, 1'b0, s.reset_flag, s.null_flag, 2'b00,
                s.busy_flag, s.syn_flag ? she_pkg::LEN_SYN : she_pkg::LEN_PLAIN};
        w[1] = {s.seq_number, s.ack_number};
        if (s.syn_flag) begin
            w[2]  = {she_pkg::VERSION, 1'b1, she_pkg::CHECKSUM_FLAG, 2'b00,
                     cfg_regs.max_outstanding};
            w[3]  = cfg_regs.max_segment_size;
            w[4]  = cfg_regs.retransmit_timeout;
            w[5]  = cfg_regs.cumulative_ack_timeout;
            w[6]  = cfg_regs.idle_timeout;
            w[7]  = cfg_regs.retry_limits;
            w[8]  = {8'h00, cfg_regs.time_unit};
            w[9]  = cfg_regs.connection_id[31:16];
            w[10] = cfg_regs.connection_id[15:0];
        end
        acc = 32'h0;
        for (int k = 0; k < n - 1; k++) acc = acc + w[k];
        while (acc > 32'hffff) acc = (acc & 32'hffff) + (acc >> 16);
        w[n-1] = ~acc[15:0];
        for (int k = 0; k < n; k++) hdr_expect_q.push_back('{w[k], 4'(k), k == n - 1});
    endtask

    // called at a rising edge; returns at the edge the request is taken
    task automatic send_seg(input t_row r);
        while ($urandom_range(99, 0) < idle_pct) begin
            seg_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_bus.valid      <= 1'b1;
        seg_bus.syn_flag   <= r.seg.syn_flag;
        seg_bus.ack_flag   <= r.seg.ack_flag;
        seg_bus.reset_flag <= r.seg.reset_flag;
        seg_bus.null_flag  <= r.seg.null_flag;
        seg_bus.busy_flag  <= r.seg.busy_flag;
        seg_bus.seq_number <= r.seg.seq_number;
        seg_bus.ack_number <= r.seg.ack_number;
        do @(posedge i_clk); while (!seg_bus.ready);
        if (r.typed) begin
            hdr_expect_q.push_back('{r.w0, 4'd0, 1'b0});
            hdr_expect_q.push_back('{r.w1, 4'd1, 1'b0});
            hdr_expect_q.push_back('{16'h0000, 4'd2, 1'b0});
            hdr_expect_q.push_back('{r.csum, she_pkg::LAST_PLAIN, 1'b1});
        end else begin
            build_expected_header(r.seg);
        end
    endtask

    task automatic run_random(input int n, input int snd_pct, input int rcv_pct);
        t_row        r;
        logic [31:0] rnd;
        idle_pct  = snd_pct;
        stall_pct <= rcv_pct;
        for (int i = 0; i < n; i++) begin
            rnd = $urandom;
            r = '0;
            r.seg = rnd[20:0];
            send_seg(r);
        end
        seg_bus.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (hdr_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= she_pkg::CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            apply_reg(i_cfg_idx, i_cfg_data);
        end
        i_cfg_idx  <= REG_BEYOND | she_pkg::CFG_IDX_W'($urandom_range(7, 0));
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        apply_reg(i_cfg_idx, i_cfg_data);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_cnt      <= HOLD_CYCLES;
            hdr_bus.ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt      <= hold_cnt - 1;
            hdr_bus.ready <= 1'b0;
        end else begin
            hdr_bus.ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && hdr_bus.valid && hdr_bus.ready) begin
            got_w = '{hdr_bus.header_word, hdr_bus.word_index, hdr_bus.last_word};
            if (hdr_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_ERR_PRINT)
                    $display("tb: unexpected word %h idx %0d last %b",
                             got_w.word, got_w.idx, got_w.last);
            end else begin
                exp_w = hdr_expect_q.pop_front();
                if (got_w != exp_w) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_ERR_PRINT)
                        $display("tb: word mismatch exp %h/%0d/%b got %h/%0d/%b",
                                 exp_w.word, exp_w.idx, exp_w.last,
                                 got_w.word, got_w.idx, got_w.last);
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        logic [31:0] vals [8];
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        seg_bus.valid      = 1'b0;
        seg_bus.syn_flag   = 1'b0;
        seg_bus.ack_flag   = 1'b0;
        seg_bus.reset_flag = 1'b0;
        seg_bus.null_flag  = 1'b0;
        seg_bus.busy_flag  = 1'b0;
        seg_bus.seq_number = '0;
        seg_bus.ack_number = '0;
        hdr_bus.ready      = 1'b0;
        hold_req           = 1'b0;
        hold_ack           = 1'b0;
        hold_cnt           = 0;
        mismatch_cnt       = 0;
        idle_pct           = 0;
        stall_pct          = 0;
        cfg_regs = '{8'd8, 16'd1024, 16'd10, 16'd100, 16'd100, 16'd4097, 8'd3, 32'd0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, register defaults
        foreach (dir_rows[i]) send_seg(dir_rows[i]);
        seg_bus.valid <= 1'b0;
        wait_idle();

        foreach (vals[i]) vals[i] = 32'h0000_0000;
        program_regs(vals);
        run_random(60, 0, 0);
        wait_idle();

        foreach (vals[i]) vals[i] = 32'hffff_ffff;
        program_regs(vals);
        run_random(80, 51, 0);
        wait_idle();

        foreach (vals[i]) vals[i] = $urandom;
        program_regs(vals);
        run_random(80, 0, 51);
        wait_idle();

        foreach (vals[i]) vals[i] = $urandom;
        program_regs(vals);
        run_random(80, 12, 12);
        wait_idle();

        // output held off while requests keep coming: input must back up
        foreach (vals[i]) vals[i] = $urandom;
        program_regs(vals);
        hold_req <= ~hold_req;
        run_random(60, 0, 0);
        wait_idle();
        run_random(40, 12, 51);
        wait_idle();

        if (mismatch_cnt == 0 && hdr_expect_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/she_pkg.sv
hdl/she_seg_if.sv
hdl/she_hdr_if.sv
hdl/she_hdr_pipe.sv
hdl/segment_header_encoder_core.sv
verif/tb.sv
